[src/ssf_pkg.sv]
// Shared types and constants for the state-space filter core.
`default_nettype none
package ssf_pkg;

  // Field widths of the stream beats
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 5;
  localparam int COEF_W   = 16;
  localparam int STATE_W  = 32;
  localparam int ORDER_W  = 3;
  localparam int PROD_W   = COEF_W + STATE_W;

  // Row and column counters cover orders up to eight
  localparam int CNT_W    = 4;

  // Fraction alignment of the sums
  localparam int Y_SHIFT  = 20;
  localparam int X_SHIFT  = 12;
  localparam int U_SCALE  = 8;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic             start;
    logic             wr;
    logic             clr;
    logic             issue;
    logic             first;
    logic             last;
    logic             fin;
    logic             commit;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] order;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fin_done;
    logic out_free;
  } sts_t;

  // Tag that travels with each product through the pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             fin;
    logic [CNT_W-1:0] row;
  } tag_t;

endpackage
`default_nettype wire

[src/ssf_ctrl.sv]
// Sequencer: request decode, term counters and result hand-off control.
`default_nettype none
module ssf_ctrl import ssf_pkg::*; #(
  parameter int MAX_ORDER = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [ORDER_W-1:0] cfg_wr_data,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_req,
  output logic                    in_ready,
  output cmd_t                    cmd,
  input  wire sts_t               sts
);

  state_t state, state_next;
  logic [ORDER_W-1:0] order_in_use;
  logic [CNT_W-1:0]   row, col, order_n, order_eff;
  logic               accept, run_end;
  req_t               req;

  assign req     = req_t'(in_req);
  assign accept  = in_valid && in_ready;
  assign run_end = (row == order_n) && (col == order_n);

  // Clamp the configured order into one to the built order
  always_comb begin
    priority if (order_in_use == '0) begin
      order_eff = CNT_W'(1);
    end else if (int'(order_in_use) > MAX_ORDER) begin
      order_eff = CNT_W'(MAX_ORDER);
    end else begin
      order_eff = CNT_W'(order_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      order_in_use <= ORDER_W'(4);
      row          <= '0;
      col          <= '0;
      order_n      <= CNT_W'(1);
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        order_in_use <= cfg_wr_data;
      end
      if (accept && req == REQ_SAMPLE) begin
        row     <= '0;
        col     <= '0;
        order_n <= order_eff;
      end else if (state == ST_RUN) begin
        if (col == order_n) begin
          col <= '0;
          row <= row + CNT_W'(1);
        end else begin
          col <= col + CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && req == REQ_SAMPLE) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.fin_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE);
    cmd        = '0;
    cmd.row    = row;
    cmd.col    = col;
    cmd.order  = order_n;
    cmd.first  = (col == '0);
    cmd.last   = (col == order_n);
    cmd.fin    = run_end;
    cmd.issue  = (state == ST_RUN);
    cmd.commit = (state == ST_COMMIT) && sts.out_free;
    if (accept) begin
      case (req)
        REQ_SAMPLE: cmd.start = 1'b1;
        REQ_WRITE:  cmd.wr    = 1'b1;
        REQ_CLEAR:  cmd.clr   = 1'b1;
        default:    ; // unknown request: drop
      endcase
    end
  end

endmodule
`default_nettype wire

[src/ssf_datapath.sv]
// Coefficient memory, state registers, shared multiply-accumulate and output register.
`default_nettype none
module ssf_datapath import ssf_pkg::*; #(
  parameter int MAX_ORDER = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cmd_t                       cmd,
  output sts_t                            sts,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  input  wire logic        [INDEX_W-1:0]  coef_index,
  input  wire logic signed [COEF_W-1:0]   coef_value,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic signed [SAMPLE_W-1:0]      sample_out,
  output logic                            saturated
);

  localparam int DEPTH  = MAX_ORDER * MAX_ORDER + 2 * MAX_ORDER + 1;
  localparam int B_BASE = MAX_ORDER * MAX_ORDER;
  localparam int C_BASE = MAX_ORDER * MAX_ORDER + MAX_ORDER;
  localparam int D_SLOT = MAX_ORDER * MAX_ORDER + 2 * MAX_ORDER;
  localparam int AW     = $clog2(DEPTH);
  localparam int WIDE_W = (AW > INDEX_W) ? AW : INDEX_W;
  localparam int IDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int ACC_W  = PROD_W + $clog2(MAX_ORDER + 1);

  localparam logic signed [ACC_W-1:0] Y_MIN = {{(ACC_W-SAMPLE_W){1'b1}}, 1'b1,
                                              {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] Y_MAX = {{(ACC_W-SAMPLE_W){1'b0}}, 1'b0,
                                              {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] X_MIN = {{(ACC_W-STATE_W){1'b1}}, 1'b1,
                                              {(STATE_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] X_MAX = {{(ACC_W-STATE_W){1'b0}}, 1'b0,
                                              {(STATE_W-1){1'b1}}};

  logic signed [COEF_W-1:0]   coef_mem [DEPTH];
  logic [DEPTH-1:0]           coef_vld;
  logic signed [COEF_W-1:0]   coef_raw, coef_op;
  logic                       coef_ok;

  logic signed [SAMPLE_W-1:0] u_reg;
  logic signed [STATE_W-1:0]  xv  [MAX_ORDER];
  logic signed [STATE_W-1:0]  nxt [MAX_ORDER];

  logic [WIDE_W-1:0]          widx;
  logic [AW-1:0]              waddr, raddr;
  logic                       wr_ok;
  logic [CNT_W-1:0]           colm1, rowm1, s3_rowm1;
  logic signed [STATE_W-1:0]  opb, opb_reg;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc, sh_y, sh_x;
  logic signed [SAMPLE_W-1:0] y_reg, y_sat;
  logic signed [STATE_W-1:0]  x_sat;
  logic                       y_clip, x_clip, sat_acc, fin_done;
  tag_t                       s1, s2, s3;

  // Coefficient write address; slots beyond the store are ignored
  assign widx  = WIDE_W'(coef_index);
  assign waddr = widx[AW-1:0];
  assign wr_ok = (int'(coef_index) < DEPTH);

  assign colm1 = cmd.col - CNT_W'(1);
  assign rowm1 = cmd.row - CNT_W'(1);

  // Row zero forms y from D and C; row r forms state r-1 from B and row r-1 of A
  always_comb begin
    if (cmd.row == '0) begin
      raddr = (cmd.col == '0) ? AW'(D_SLOT) : AW'(C_BASE + int'(colm1));
    end else if (cmd.col == '0) begin
      raddr = AW'(B_BASE + int'(rowm1));
    end else begin
      raddr = AW'(int'(rowm1) * MAX_ORDER + int'(colm1));
    end
    if (cmd.col == '0) begin
      opb = {{(STATE_W-SAMPLE_W-U_SCALE){u_reg[SAMPLE_W-1]}}, u_reg, {U_SCALE{1'b0}}};
    end else begin
      opb = xv[colm1[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) begin
      coef_mem[waddr] <= coef_value;
    end
    if (cmd.issue) begin
      coef_raw <= coef_mem[raddr];
      coef_ok  <= coef_vld[raddr];
      opb_reg  <= opb;
    end
  end

  // Entries never written read as zero
  assign coef_op = coef_ok ? coef_raw : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
    end else if (cmd.wr && wr_ok) begin
      coef_vld[waddr] <= 1'b1;
    end
  end

  // Pipeline tags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1       <= '0;
      s2       <= '0;
      s3       <= '0;
      fin_done <= 1'b0;
    end else begin
      s1.valid <= cmd.issue;
      s1.first <= cmd.first;
      s1.last  <= cmd.last;
      s1.fin   <= cmd.fin;
      s1.row   <= cmd.row;
      s2       <= s1;
      s3       <= s2;
      fin_done <= s3.valid && s3.last && s3.fin;
    end
  end

  // Multiply, then accumulate one stage later
  always_ff @(posedge clk) begin
    if (s1.valid) begin
      prod <= coef_op * opb_reg;
    end
    if (s2.valid) begin
      if (s2.first) begin
        acc <= {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      end else begin
        acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      end
    end
  end

  // Floor shift and clip of a finished row
  always_comb begin
    sh_y   = acc >>> Y_SHIFT;
    sh_x   = acc >>> X_SHIFT;
    y_clip = (sh_y < Y_MIN) || (sh_y > Y_MAX);
    x_clip = (sh_x < X_MIN) || (sh_x > X_MAX);
    priority if (sh_y < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_W-1:0];
    end else if (sh_y > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_W-1:0];
    end else begin
      y_sat = sh_y[SAMPLE_W-1:0];
    end
    priority if (sh_x < X_MIN) begin
      x_sat = X_MIN[STATE_W-1:0];
    end else if (sh_x > X_MAX) begin
      x_sat = X_MAX[STATE_W-1:0];
    end else begin
      x_sat = sh_x[STATE_W-1:0];
    end
  end

  assign s3_rowm1 = s3.row - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      u_reg   <= sample_in;
      sat_acc <= 1'b0;
    end else if (s3.valid && s3.last) begin
      if (s3.row == '0) begin
        y_reg   <= y_sat;
        sat_acc <= sat_acc | y_clip;
      end else begin
        nxt[s3_rowm1[IDX_W-1:0]] <= x_sat;
        sat_acc <= sat_acc | x_clip;
      end
    end
  end

  // State vector; unused elements are left alone by a sample
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        xv[i] <= '0;
      end
    end else if (cmd.clr) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        xv[i] <= '0;
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        if (i < int'(cmd.order)) begin
          xv[i] <= nxt[i];
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      sample_out <= y_reg;
      saturated  <= sat_acc;
    end
  end

  assign sts.fin_done = fin_done;
  assign sts.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

[src/state_space_filter_siso_core.sv]
// Top level of the single-input single-output state-space filter core.
// A sample beat runs (n+1)^2 products, n the order in use, through the one shared multiply-accumulate unit,
// one product per cycle, then drains its pipeline and waits for the output register to be free before commit;
// no new beat is taken until that commit, while write and clear beats leave the input open.
// Reset (rst, synchronous, active high) zeroes the coefficients and the state, sets the order to four.
`default_nettype none
module state_space_filter_siso_core import ssf_pkg::*; #(
  parameter int MAX_ORDER = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [ORDER_W-1:0] cfg_wr_data,  // order_in_use
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [39:0]        s_tdata,      // sample_in, coef_index, coef_value, zero pad
  input  wire logic [1:0]         s_tuser,      // req_type
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [15:0]             m_tdata,      // sample_out
  output logic [0:0]              m_tuser       // saturated
);

  cmd_t cmd;
  sts_t sts;
  logic signed [SAMPLE_W-1:0] y_out;
  logic                       sat_out;

  ssf_ctrl #(
    .MAX_ORDER (MAX_ORDER)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_tvalid),
    .in_req      (s_tuser),
    .in_ready    (s_tready),
    .cmd         (cmd),
    .sts         (sts)
  );

  ssf_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .sample_in  (s_tdata[15:0]),
    .coef_index (s_tdata[20:16]),
    .coef_value (s_tdata[36:21]),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .sample_out (y_out),
    .saturated  (sat_out)
  );

  assign m_tdata    = y_out;
  assign m_tuser[0] = sat_out;

endmodule
`default_nettype wire

[src/ssf_checker.sv]
// Port-level checker for the filter core, bound to the top level.
`default_nettype none
module ssf_port_checker import ssf_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_tvalid,
  input wire logic               s_tready,
  input wire logic [1:0]         s_tuser,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [15:0]        m_tdata,
  input wire logic [0:0]         m_tuser
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // A sample beat occupies the sequencer
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == REQ_SAMPLE |=> !s_tready)
    else $error("input ready right after a sample beat");

  // Write, clear and unknown beats leave the input open
  a_other_open: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != REQ_SAMPLE |=> s_tready)
    else $error("input closed after a non-sample beat");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind state_space_filter_siso_core ssf_port_checker u_ssf_port_checker (.*);
`default_nettype wire
